[rtl/etf_pkg.sv]
// Shared types and constants of the escape-time fractal engine.
// Used by every module of the block; depends on nothing.
`default_nettype none

package etf_pkg;

	// Field widths
	localparam int PIX_W   = 10;
	localparam int COORD_W = 32;
	localparam int COUNT_W = 16;
	localparam int SHADE_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Fixed-point format and internal widths
	localparam int FRAC_BITS = 28;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int WIDE_W    = PROD_W + 2;
	localparam int MAP_W     = PIX_W + 1 + COORD_W;
	localparam logic signed [WIDE_W-1:0] ESC_BOUND = WIDE_W'(4) <<< FRAC_BITS;

	// Shade divider: quotient never exceeds 255, so one bit per step
	localparam int SHADE_MAX = 255;
	localparam int NUM_W     = COUNT_W + SHADE_W;
	localparam int DIV_STEPS = SHADE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Register reset values
	localparam logic signed [COORD_W-1:0] X_ORIGIN_RST = -32'sd536870912;
	localparam logic signed [COORD_W-1:0] Y_ORIGIN_RST = -32'sd402653184;
	localparam logic signed [COORD_W-1:0] STEP_RST     = 32'sd786432;
	localparam logic [COUNT_W-1:0]        MAX_ITER_RST = 16'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE       = 3'd0,
		CFG_X_ORIGIN   = 3'd1,
		CFG_X_STEP     = 3'd2,
		CFG_Y_ORIGIN   = 3'd3,
		CFG_Y_STEP     = 3'd4,
		CFG_JULIA_RE   = 3'd5,
		CFG_JULIA_IM   = 3'd6,
		CFG_MAX_ITER   = 3'd7
	} cfg_idx_t;

	typedef enum logic {
		MODE_MANDELBROT = 1'b0,
		MODE_JULIA      = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                      mode;
		logic signed [COORD_W-1:0]  x_origin;
		logic signed [COORD_W-1:0]  x_step;
		logic signed [COORD_W-1:0]  y_origin;
		logic signed [COORD_W-1:0]  y_step;
		logic signed [COORD_W-1:0]  julia_real;
		logic signed [COORD_W-1:0]  julia_imag;
		logic [COUNT_W-1:0]         max_iterations;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_MUL,
		ST_UPD,
		ST_DIV,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic                 capture;
		logic                 init;
		logic                 mul;
		logic                 upd;
		logic                 div_step;
		logic [DIV_CNT_W-1:0] div_bit;
		logic                 emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic stop;
	} sts_t;

	// Clamp a wide signed value to the coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'({1'b0, {(COORD_W-1){1'b1}}});
		lo = ~hi;
		if (v > hi) begin
			return hi[COORD_W-1:0];
		end else if (v < lo) begin
			return lo[COORD_W-1:0];
		end
		return v[COORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/etf_if.sv]
// Valid/ready channel interfaces for pixel positions and pixel results.
// Depends on etf_pkg for field widths.
`default_nettype none

interface etf_pix_if;
	import etf_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] column;
	logic [PIX_W-1:0] row;
	modport source (output valid, output column, output row, input ready);
	modport sink (input valid, input column, input row, output ready);
endinterface

interface etf_res_if;
	import etf_pkg::*;
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   out_column;
	logic [PIX_W-1:0]   out_row;
	logic [COUNT_W-1:0] iteration_count;
	logic [SHADE_W-1:0] shade;
	modport source (output valid, output out_column, output out_row,
		output iteration_count, output shade, input ready);
	modport sink (input valid, input out_column, input out_row,
		input iteration_count, input shade, output ready);
endinterface

`default_nettype wire

[rtl/escape_time_fractal_engine.sv]
// Escape-time fractal engine (Mandelbrot/Julia) with configuration registers.
// Each pixel is captured, mapped and iterated by a multiply/update loop
// (one pass per iteration, plus one escape check), then shaded by the
// shade divider; the next pixel is taken only after its result is emitted.
// A pending result in the output register does not block the next pixel.
// Reset (arst_n low, asynchronous) returns to idle and restores the configuration registers.
`default_nettype none

module escape_time_fractal_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	etf_pix_if.sink                          pixel,
	etf_res_if.source                        result,
	input  logic                             cfg_we,
	input  logic [etf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [etf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import etf_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= MODE_MANDELBROT;
			cfg_q.x_origin       <= X_ORIGIN_RST;
			cfg_q.x_step         <= STEP_RST;
			cfg_q.y_origin       <= Y_ORIGIN_RST;
			cfg_q.y_step         <= STEP_RST;
			cfg_q.julia_real     <= '0;
			cfg_q.julia_imag     <= '0;
			cfg_q.max_iterations <= MAX_ITER_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MODE:     cfg_q.mode           <= mode_t'(cfg_data[0]);
				CFG_X_ORIGIN: cfg_q.x_origin       <= cfg_data;
				CFG_X_STEP:   cfg_q.x_step         <= cfg_data;
				CFG_Y_ORIGIN: cfg_q.y_origin       <= cfg_data;
				CFG_Y_STEP:   cfg_q.y_step         <= cfg_data;
				CFG_JULIA_RE: cfg_q.julia_real     <= cfg_data;
				CFG_JULIA_IM: cfg_q.julia_imag     <= cfg_data;
				CFG_MAX_ITER: cfg_q.max_iterations <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	etf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	etf_datapath u_datapath (
		.clk             (clk),
		.cfg             (cfg_q),
		.cmd             (cmd),
		.column          (pixel.column),
		.row             (pixel.row),
		.sts             (sts),
		.out_column      (result.out_column),
		.out_row         (result.out_row),
		.iteration_count (result.iteration_count),
		.shade           (result.shade)
	);

endmodule

`default_nettype wire

[rtl/etf_ctrl.sv]
// Controller of the fractal engine: sequences map, iterate, divide and emit.
// Depends on etf_pkg for state, command and status types.
`default_nettype none

module etf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  etf_pkg::sts_t sts,
	output etf_pkg::cmd_t cmd
);
	import etf_pkg::*;

	state_t               st_q;
	state_t               st_next;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;

	// State, divider step counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_next;
			if (st_q == ST_UPD) begin
				div_cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (st_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		st_next     = st_q;
		cmd         = '0;
		cmd.div_bit = div_cnt_q;
		in_ready    = 1'b0;
		case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					st_next     = ST_MAP;
				end
			end
			ST_MAP: begin
				cmd.init = 1'b1;
				st_next  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				st_next = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				st_next = sts.stop ? ST_DIV : ST_MUL;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == '0) begin
					st_next = ST_DONE;
				end
			end
			ST_DONE: begin
				// Load the output register once it is free or being drained
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					st_next  = ST_IDLE;
				end
			end
			default: begin
				st_next = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/etf_datapath.sv]
// Datapath of the fractal engine: point mapping, z iteration, shade divider
// and the result register. Depends on etf_pkg; driven by etf_ctrl commands.
`default_nettype none

module etf_datapath (
	input  logic                          clk,
	input  etf_pkg::cfg_t                 cfg,
	input  etf_pkg::cmd_t                 cmd,
	input  logic [etf_pkg::PIX_W-1:0]     column,
	input  logic [etf_pkg::PIX_W-1:0]     row,
	output etf_pkg::sts_t                 sts,
	output logic [etf_pkg::PIX_W-1:0]     out_column,
	output logic [etf_pkg::PIX_W-1:0]     out_row,
	output logic [etf_pkg::COUNT_W-1:0]   iteration_count,
	output logic [etf_pkg::SHADE_W-1:0]   shade
);
	import etf_pkg::*;

	logic [PIX_W-1:0]          col_q;
	logic [PIX_W-1:0]          row_q;
	logic signed [MAP_W-1:0]   mx_q;
	logic signed [MAP_W-1:0]   my_q;
	logic signed [COORD_W-1:0] zr_q;
	logic signed [COORD_W-1:0] zi_q;
	logic signed [COORD_W-1:0] cr_q;
	logic signed [COORD_W-1:0] ci_q;
	logic [COUNT_W-1:0]        count_q;
	logic signed [PROD_W-1:0]  xx_q;
	logic signed [PROD_W-1:0]  yy_q;
	logic signed [PROD_W-1:0]  xy_q;
	logic [NUM_W-1:0]          num_q;
	logic [SHADE_W-1:0]        quo_q;
	logic [PIX_W-1:0]          res_col_q;
	logic [PIX_W-1:0]          res_row_q;
	logic [COUNT_W-1:0]        res_count_q;
	logic [SHADE_W-1:0]        res_shade_q;

	logic signed [COORD_W-1:0] px;
	logic signed [COORD_W-1:0] py;
	logic signed [WIDE_W-1:0]  xx_w;
	logic signed [WIDE_W-1:0]  yy_w;
	logic signed [WIDE_W-1:0]  xy2_w;
	logic signed [WIDE_W-1:0]  mag_w;
	logic signed [COORD_W-1:0] zr_next;
	logic signed [COORD_W-1:0] zi_next;
	logic [NUM_W-1:0]          trial;

	// Map position to point: origin plus scaled index, clamped
	assign px = sat_coord(WIDE_W'(cfg.x_origin) + WIDE_W'(mx_q));
	assign py = sat_coord(WIDE_W'(cfg.y_origin) + WIDE_W'(my_q));

	// Scale the products back, floor rounding; cross term doubled
	assign xx_w  = WIDE_W'(xx_q >>> FRAC_BITS);
	assign yy_w  = WIDE_W'(yy_q >>> FRAC_BITS);
	assign xy2_w = WIDE_W'(xy_q >>> (FRAC_BITS - 1));
	assign mag_w = xx_w + yy_w;

	assign sts.stop = (mag_w > ESC_BOUND) || (count_q >= cfg.max_iterations);
	assign zr_next  = sat_coord(xx_w - yy_w + WIDE_W'(cr_q));
	assign zi_next  = sat_coord(xy2_w + WIDE_W'(ci_q));

	// Divider trial subtrahend for the current quotient bit
	assign trial = NUM_W'(cfg.max_iterations) << cmd.div_bit;

	always_ff @(posedge clk) begin
		// Capture the position and scale it by the step
		if (cmd.capture) begin
			col_q <= column;
			row_q <= row;
			mx_q  <= $signed({1'b0, column}) * cfg.x_step;
			my_q  <= $signed({1'b0, row}) * cfg.y_step;
		end
		// Seed z and c by mode
		if (cmd.init) begin
			count_q <= '0;
			if (cfg.mode == MODE_JULIA) begin
				zr_q <= px;
				zi_q <= py;
				cr_q <= cfg.julia_real;
				ci_q <= cfg.julia_imag;
			end else begin
				zr_q <= '0;
				zi_q <= '0;
				cr_q <= px;
				ci_q <= py;
			end
		end
		// Form the squares and the cross product
		if (cmd.mul) begin
			xx_q <= zr_q * zr_q;
			yy_q <= zi_q * zi_q;
			xy_q <= zr_q * zi_q;
		end
		// Advance z, or load the divider with 255 times the count
		if (cmd.upd) begin
			if (sts.stop) begin
				num_q <= {count_q, {SHADE_W{1'b0}}} - NUM_W'(count_q);
				quo_q <= '0;
			end else begin
				zr_q    <= zr_next;
				zi_q    <= zi_next;
				count_q <= count_q + 1'b1;
			end
		end
		// Restoring division, one quotient bit per step
		if (cmd.div_step && (num_q >= trial)) begin
			num_q              <= num_q - trial;
			quo_q[cmd.div_bit] <= 1'b1;
		end
		// Hand the result to the output register
		if (cmd.emit) begin
			res_col_q   <= col_q;
			res_row_q   <= row_q;
			res_count_q <= count_q;
			res_shade_q <= (cfg.max_iterations == '0) ? '0 : quo_q;
		end
	end

	assign out_column      = res_col_q;
	assign out_row         = res_row_q;
	assign iteration_count = res_count_q;
	assign shade           = res_shade_q;

endmodule

`default_nettype wire

[rtl/etf_checker.sv]
// Port-level checks of the fractal engine, bound to the top level.
// Depends on etf_pkg; sees only the top-level ports.
`default_nettype none

module etf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [etf_pkg::PIX_W-1:0]        out_column,
	input logic [etf_pkg::PIX_W-1:0]        out_row,
	input logic [etf_pkg::COUNT_W-1:0]      iteration_count,
	input logic [etf_pkg::SHADE_W-1:0]      shade,
	input logic                             cfg_we,
	input logic [etf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input logic [etf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import etf_pkg::*;

	logic [COUNT_W-1:0] max_iter_q;

	// Track the iteration limit from register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RST;
		end else if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_MAX_ITER)) begin
			max_iter_q <= cfg_data[COUNT_W-1:0];
		end
	end

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_column) && $stable(out_row)
			&& $stable(iteration_count) && $stable(shade))
		else $error("result payload changed while stalled");

	// One pixel in work at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("pixel taken while another is in work");

	// Count never passes the limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> iteration_count <= max_iter_q)
		else $error("iteration count above limit");

	// A pixel that reaches the limit is full white
	a_full_shade: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (iteration_count == max_iter_q) && (max_iter_q != '0)
			|-> shade == SHADE_W'(SHADE_MAX))
		else $error("shade wrong at iteration limit");

endmodule

bind escape_time_fractal_engine etf_checker u_etf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (pixel.valid),
	.in_ready        (pixel.ready),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.out_column      (result.out_column),
	.out_row         (result.out_row),
	.iteration_count (result.iteration_count),
	.shade           (result.shade),
	.cfg_we          (cfg_we),
	.cfg_index       (cfg_index),
	.cfg_data        (cfg_data)
);

`default_nettype wire

[test/tb_escape_time_fractal_engine.sv]
// Testbench of the escape-time fractal engine: scripted corner cases, then random
// register settings and pixel streams, scored against a behavioral orbit model.
// Depends on etf_pkg, etf_pix_if/etf_res_if and escape_time_fractal_engine.
`default_nettype none

module tb_escape_time_fractal_engine;
	import etf_pkg::*;

	localparam logic signed [COORD_W-1:0] FX_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] FX_MIN = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] FX_TWO = 32'sd536870912;
	localparam longint WIDE_MAX = 64'sd2147483647;
	localparam longint WIDE_MIN = -64'sd2147483648;
	localparam int SETTLE_CYCLES    = 16;
	localparam int RANDOM_PHASES    = 14;
	localparam int PIXELS_PER_PHASE = 100;
	localparam int QUIET_PHASE      = 7;

	typedef struct packed {
		logic [PIX_W-1:0]   column;
		logic [PIX_W-1:0]   row;
		logic [COUNT_W-1:0] count;
		logic [SHADE_W-1:0] shade;
	} pixel_result_t;

	typedef struct packed {
		logic               load;
		cfg_t               cfg;
		logic [PIX_W-1:0]   column;
		logic [PIX_W-1:0]   row;
		logic               known;
		logic [COUNT_W-1:0] count;
		logic [SHADE_W-1:0] shade;
	} script_row_t;

	// Register settings used by the scripted part
	localparam cfg_t SET_DEFAULT = '{MODE_MANDELBROT, X_ORIGIN_RST, STEP_RST, Y_ORIGIN_RST,
		STEP_RST, 32'sd0, 32'sd0, MAX_ITER_RST};
	localparam cfg_t SET_ZERO_LIMIT = '{MODE_MANDELBROT, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
		32'sd0, 32'sd0, 16'd0};
	localparam cfg_t SET_LIMIT_ONE = '{MODE_MANDELBROT, X_ORIGIN_RST, STEP_RST, Y_ORIGIN_RST,
		STEP_RST, 32'sd0, 32'sd0, 16'd1};
	localparam cfg_t SET_EDGE_CIRCLE = '{MODE_MANDELBROT, -FX_TWO, 32'sd0, 32'sd0, 32'sd0,
		32'sd0, 32'sd0, 16'd16};
	localparam cfg_t SET_ORIGIN_LONG = '{MODE_MANDELBROT, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
		32'sd0, 32'sd0, 16'd65535};
	localparam cfg_t SET_FAR_LONG = '{MODE_MANDELBROT, X_ORIGIN_RST, 32'sd0, Y_ORIGIN_RST,
		32'sd0, 32'sd0, 32'sd0, 16'd65535};
	localparam cfg_t SET_JULIA_FAR = '{MODE_JULIA, FX_MAX, 32'sd0, 32'sd0, 32'sd0,
		32'sd0, 32'sd0, 16'd100};
	localparam cfg_t SET_JULIA_SAT = '{MODE_JULIA, FX_MIN, FX_MIN, FX_MAX, FX_MAX,
		32'sd0, 32'sd0, 16'd100};
	localparam cfg_t SET_CORNER = '{MODE_MANDELBROT, FX_MIN, FX_MIN, FX_MIN, FX_MIN,
		32'sd0, 32'sd0, 16'd100};
	localparam cfg_t SET_JULIA_RE_SAT = '{MODE_JULIA, FX_TWO, 32'sd0, 32'sd0, 32'sd0,
		FX_MAX, 32'sd0, 16'd10};
	localparam cfg_t SET_JULIA_IM_SAT = '{MODE_JULIA, 32'sd0, 32'sd0, FX_TWO, 32'sd0,
		FX_MIN, 32'sd0, 16'd10};
	localparam cfg_t SET_JULIA_CLASSIC = '{MODE_JULIA, -32'sd402653184, STEP_RST,
		-32'sd402653184, STEP_RST, -32'sd214748365, 32'sd41875931, 16'd64};
	localparam cfg_t SET_FLIPPED = '{MODE_MANDELBROT, 32'sd134217728, -32'sd786432,
		32'sd402653184, -32'sd786432, 32'sd0, 32'sd0, 16'd40};

	// load, settings, column, row, known, count, shade
	localparam script_row_t PIXEL_SCRIPT [22] = '{
		'{1'b0, SET_DEFAULT,       10'd0,    10'd0,    1'b1, 16'd1,     8'd0},
		'{1'b0, SET_DEFAULT,       10'd1023, 10'd1023, 1'b0, 16'd0,     8'd0},
		'{1'b0, SET_DEFAULT,       10'd683,  10'd512,  1'b0, 16'd0,     8'd0},
		'{1'b1, SET_ZERO_LIMIT,    10'd5,    10'd5,    1'b1, 16'd0,     8'd0},
		'{1'b0, SET_ZERO_LIMIT,    10'd1023, 10'd0,    1'b1, 16'd0,     8'd0},
		'{1'b1, SET_LIMIT_ONE,     10'd1023, 10'd0,    1'b1, 16'd1,     8'd255},
		'{1'b0, SET_LIMIT_ONE,     10'd0,    10'd1023, 1'b1, 16'd1,     8'd255},
		'{1'b1, SET_EDGE_CIRCLE,   10'd7,    10'd9,    1'b1, 16'd16,    8'd255},
		'{1'b1, SET_ORIGIN_LONG,   10'd1023, 10'd1023, 1'b1, 16'd65535, 8'd255},
		'{1'b1, SET_FAR_LONG,      10'd0,    10'd0,    1'b1, 16'd1,     8'd0},
		'{1'b1, SET_JULIA_FAR,     10'd0,    10'd0,    1'b1, 16'd0,     8'd0},
		'{1'b1, SET_JULIA_SAT,     10'd1023, 10'd1023, 1'b1, 16'd0,     8'd0},
		'{1'b0, SET_JULIA_SAT,     10'd1,    10'd1,    1'b1, 16'd0,     8'd0},
		'{1'b1, SET_CORNER,        10'd1023, 10'd1023, 1'b1, 16'd1,     8'd2},
		'{1'b0, SET_CORNER,        10'd0,    10'd1023, 1'b1, 16'd1,     8'd2},
		'{1'b1, SET_JULIA_RE_SAT,  10'd0,    10'd0,    1'b1, 16'd1,     8'd25},
		'{1'b1, SET_JULIA_IM_SAT,  10'd0,    10'd0,    1'b1, 16'd1,     8'd25},
		'{1'b1, SET_JULIA_CLASSIC, 10'd512,  10'd512,  1'b0, 16'd0,     8'd0},
		'{1'b0, SET_JULIA_CLASSIC, 10'd300,  10'd700,  1'b0, 16'd0,     8'd0},
		'{1'b0, SET_JULIA_CLASSIC, 10'd850,  10'd128,  1'b0, 16'd0,     8'd0},
		'{1'b1, SET_FLIPPED,       10'd170,  10'd512,  1'b0, 16'd0,     8'd0},
		'{1'b0, SET_FLIPPED,       10'd1000, 10'd3,    1'b0, 16'd0,     8'd0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	etf_pix_if pix ();
	etf_res_if res ();

	cfg_t          shadow_cfg;
	pixel_result_t pixels_in_flight [$];
	pixel_result_t oldest_pixel;
	int            mismatch_count;
	int            idle_pct;
	int            sink_hold;

	escape_time_fractal_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pix),
		.result    (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint clamp_coord(input longint v);
		if (v > WIDE_MAX) begin
			return WIDE_MAX;
		end else if (v < WIDE_MIN) begin
			return WIDE_MIN;
		end
		return v;
	endfunction

	// Map the pixel to the plane and run the orbit until escape or the limit
	function automatic pixel_result_t shade_pixel(input cfg_t s, input logic [PIX_W-1:0] col,
			input logic [PIX_W-1:0] rw);
		longint        pr;
		longint        pim;
		longint        zr;
		longint        zi;
		longint        cr;
		longint        ci;
		longint        xx;
		longint        yy;
		longint        bound;
		int unsigned   count;
		int unsigned   limit;
		pixel_result_t r;
		bound = longint'(4) <<< FRAC_BITS;
		pr = clamp_coord(longint'($signed(s.x_origin)) + longint'(col) * longint'($signed(s.x_step)));
		pim = clamp_coord(longint'($signed(s.y_origin)) + longint'(rw) * longint'($signed(s.y_step)));
		if (s.mode == MODE_JULIA) begin
			zr = pr;
			zi = pim;
			cr = longint'($signed(s.julia_real));
			ci = longint'($signed(s.julia_imag));
		end else begin
			zr = 0;
			zi = 0;
			cr = pr;
			ci = pim;
		end
		limit = s.max_iterations;
		count = 0;
		xx = (zr * zr) >>> FRAC_BITS;
		yy = (zi * zi) >>> FRAC_BITS;
		// stay in the loop while on or inside the radius-2 circle
		while (xx + yy <= bound && count < limit) begin
			zi = clamp_coord(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
			zr = clamp_coord(xx - yy + cr);
			count++;
			xx = (zr * zr) >>> FRAC_BITS;
			yy = (zi * zi) >>> FRAC_BITS;
		end
		r.column = col;
		r.row = rw;
		r.count = COUNT_W'(count);
		r.shade = (limit == 0) ? '0 : SHADE_W'((SHADE_MAX * count) / limit);
		return r;
	endfunction

	// Mostly view windows around the set; now and then raw register noise
	function automatic cfg_t draw_settings();
		cfg_t        s;
		int unsigned pick;
		s.mode = mode_t'($urandom_range(0, 1));
		if ($urandom_range(0, 4) != 0) begin
			s.x_step = COORD_W'($urandom_range(0, 1572864));
			s.y_step = COORD_W'($urandom_range(0, 1572864));
			if ($urandom_range(0, 1) != 0) begin
				s.x_step = -s.x_step;
			end
			if ($urandom_range(0, 1) != 0) begin
				s.y_step = -s.y_step;
			end
			s.x_origin = COORD_W'($urandom_range(0, 805306368) - 536870912);
			s.y_origin = COORD_W'($urandom_range(0, 805306368) - 402653184);
			s.julia_real = COORD_W'($urandom_range(0, 536870912) - 268435456);
			s.julia_imag = COORD_W'($urandom_range(0, 536870912) - 268435456);
		end else begin
			s.x_origin = $urandom();
			s.x_step = $urandom();
			s.y_origin = $urandom();
			s.y_step = $urandom();
			s.julia_real = $urandom();
			s.julia_imag = $urandom();
		end
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			s.max_iterations = COUNT_W'($urandom_range(1, 40));
		end else if (pick < 9) begin
			s.max_iterations = COUNT_W'($urandom_range(41, 300));
		end else begin
			s.max_iterations = COUNT_W'($urandom_range(0, 2));
		end
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got, input int unsigned want,
			input pixel_result_t px);
		if (got != want) begin
			report_mismatch($sformatf("pixel (%0d,%0d) %s: got %0d, want %0d",
				px.column, px.row, name, got, want));
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	// Write every register, then drop the write enable
	task automatic load_settings(input cfg_t s);
		write_reg(CFG_MODE, CFG_DATA_W'(s.mode));
		write_reg(CFG_X_ORIGIN, s.x_origin);
		write_reg(CFG_X_STEP, s.x_step);
		write_reg(CFG_Y_ORIGIN, s.y_origin);
		write_reg(CFG_Y_STEP, s.y_step);
		write_reg(CFG_JULIA_RE, s.julia_real);
		write_reg(CFG_JULIA_IM, s.julia_imag);
		write_reg(CFG_MAX_ITER, CFG_DATA_W'(s.max_iterations));
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_cfg = s;
	endtask

	// Offer one pixel after an optional gap and hold it until the transfer
	task automatic send_pixel(input pixel_result_t want);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 60) : 1;
		end
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.column <= want.column;
		pix.row <= want.row;
		do @(posedge clk); while (!pix.ready);
		pixels_in_flight.push_back(want);
	endtask

	// Drop valid and wait until every pixel in flight has come back
	task automatic settle();
		pix.valid <= 1'b0;
		while (pixels_in_flight.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Score each result transfer, then draw the next ready value; stalls
	// start a third as often as the input gaps (idle_pct / 3)
	always @(posedge clk) begin
		if (res.valid && res.ready) begin
			if (pixels_in_flight.size() == 0) begin
				report_mismatch($sformatf("result for pixel (%0d,%0d) with none outstanding",
					res.out_column, res.out_row));
			end else begin
				oldest_pixel = pixels_in_flight.pop_front();
				check_field("column", res.out_column, oldest_pixel.column, oldest_pixel);
				check_field("row", res.out_row, oldest_pixel.row, oldest_pixel);
				check_field("iteration_count", res.iteration_count, oldest_pixel.count,
					oldest_pixel);
				check_field("shade", res.shade, oldest_pixel.shade, oldest_pixel);
			end
		end
		if (sink_hold > 0) begin
			sink_hold--;
			res.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < idle_pct / 3) begin
			sink_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : 0;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	initial begin
		pixel_result_t want;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.column = '0;
		pix.row = '0;
		res.ready = 1'b0;
		idle_pct = 25;
		sink_hold = 0;
		mismatch_count = 0;
		shadow_cfg = SET_DEFAULT;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Scripted corner cases, starting from the reset settings
		foreach (PIXEL_SCRIPT[i]) begin
			if (PIXEL_SCRIPT[i].load) begin
				settle();
				load_settings(PIXEL_SCRIPT[i].cfg);
			end
			if (PIXEL_SCRIPT[i].known) begin
				want = '{PIXEL_SCRIPT[i].column, PIXEL_SCRIPT[i].row,
					PIXEL_SCRIPT[i].count, PIXEL_SCRIPT[i].shade};
			end else begin
				want = shade_pixel(shadow_cfg, PIXEL_SCRIPT[i].column, PIXEL_SCRIPT[i].row);
			end
			send_pixel(want);
		end

		// Random phases: new settings, then a stream of random pixels
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			load_settings(draw_settings());
			idle_pct = (p == QUIET_PHASE) ? 0 : 25;
			repeat (PIXELS_PER_PHASE) begin
				send_pixel(shade_pixel(shadow_cfg, PIX_W'($urandom), PIX_W'($urandom)));
			end
		end
		settle();

		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#100_000_000;
		$display("watchdog expired with %0d pixels outstanding", pixels_in_flight.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
